// ===== rtl/aes_pkg.sv =====
package aes_pkg;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_KEY_HI = 3'd1;
  localparam logic [2:0] CFG_KEY_LO = 3'd2;
  localparam logic [2:0] CFG_IV_HI  = 3'd3;
  localparam logic [2:0] CFG_IV_LO  = 3'd4;

  localparam int unsigned NUM_ROUNDS = 10;

  typedef struct packed {
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [4:0]  valid_bytes;
    logic        restart;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_bytes;
  } out_word_t;

  // what travels from cell to cell
  typedef struct packed {
    logic         dec;
    logic         ctr;
    logic [127:0] st;
    logic [127:0] key;
    logic [127:0] data;
    logic [4:0]   count;
  } stage_t;

  typedef logic [7:0] byte_tab_t [0:255];

  localparam byte_tab_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic byte_tab_t make_rsbox();
    byte_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[SBOX[i]] = i[7:0];
    end
    return tab;
  endfunction

  localparam byte_tab_t RSBOX = make_rsbox();

  localparam logic [7:0] RCON [1:10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_state(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = SBOX[s[127-8*i -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_state(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = RSBOX[s[127-8*i -: 8]];
    end
    return t;
  endfunction

  // byte i sits at row i%4, column i/4
  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] a);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[31:24];
    a1 = a[23:16];
    a2 = a[15:8];
    a3 = a[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [7:0] mul_e(input logic [7:0] a);
    logic [7:0] x2, x4, x8;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    return x8 ^ x4 ^ x2;
  endfunction

  function automatic logic [7:0] mul_b(input logic [7:0] a);
    logic [7:0] x2, x8;
    x2 = xtime(a);
    x8 = xtime(xtime(x2));
    return x8 ^ x2 ^ a;
  endfunction

  function automatic logic [7:0] mul_d(input logic [7:0] a);
    logic [7:0] x4, x8;
    x4 = xtime(xtime(a));
    x8 = xtime(x4);
    return x8 ^ x4 ^ a;
  endfunction

  function automatic logic [7:0] mul_9(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ a;
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[31:24];
    a1 = a[23:16];
    a2 = a[15:8];
    a3 = a[7:0];
    return {mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3),
            mul_9(a0) ^ mul_e(a1) ^ mul_b(a2) ^ mul_d(a3),
            mul_d(a0) ^ mul_9(a1) ^ mul_e(a2) ^ mul_b(a3),
            mul_b(a0) ^ mul_d(a1) ^ mul_9(a2) ^ mul_e(a3)};
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
    end
    return t;
  endfunction

  // round key r-1 to round key r
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // round key r back to round key r-1, rc belongs to round r
  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    t  = sub_word({p3[23:0], p3[31:24]}) ^ {rc, 24'h0};
    p0 = k[127:96] ^ t;
    return {p0, p1, p2, p3};
  endfunction

endpackage

// ===== rtl/aes_round_cell.sv =====
module aes_round_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  aes_pkg::stage_t      stage_i,
  input  logic [7:0]           enc_rcon_i,
  input  logic [7:0]           dec_rcon_i,
  input  logic                 last_i,
  output logic                 valid_o,
  output aes_pkg::stage_t      stage_o
);

  logic            valid_q;
  aes_pkg::stage_t stage_q, stage_d;
  logic [127:0]    enc_key, dec_key, enc_sr, dec_t;

  always_comb begin
    enc_key = aes_pkg::key_fwd(stage_i.key, enc_rcon_i);
    dec_key = aes_pkg::key_inv(stage_i.key, dec_rcon_i);
    enc_sr  = aes_pkg::shift_rows(aes_pkg::sub_state(stage_i.st));
    dec_t   = aes_pkg::inv_sub_state(aes_pkg::inv_shift_rows(stage_i.st)) ^ dec_key;
    stage_d = stage_i;
    if (stage_i.dec) begin
      stage_d.key = dec_key;
      stage_d.st  = last_i ? dec_t : aes_pkg::inv_mix_cols(dec_t);
    end else begin
      stage_d.key = enc_key;
      stage_d.st  = (last_i ? enc_sr : aes_pkg::mix_cols(enc_sr)) ^ enc_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== rtl/aes_key_last.sv =====
module aes_key_last (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] key_i,
  output logic         busy_o,
  output logic [127:0] rk_o
);

  logic [127:0] rk_q, rk_d;
  logic [3:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;

  always_comb begin
    rk_d   = rk_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rk_d   = key_i;
      cnt_d  = 4'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rk_d  = aes_pkg::key_fwd(rk_q, aes_pkg::RCON[cnt_q]);
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(aes_pkg::NUM_ROUNDS)) begin
        busy_d = 1'b0;
      end
    end
  end

  // reset key is zero, so expansion of the zero key runs out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q   <= '0;
      cnt_q  <= 4'd1;
      busy_q <= 1'b1;
    end else begin
      rk_q   <= rk_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign rk_o   = rk_q;

endmodule

// ===== rtl/aes128_ecb_ctr_cipher.sv =====
// path: an accepted word passes the input stage, ten round cells and the output
// register to its result word; throughput: one 128-bit block per cycle, set by
// the ten-cell round chain, while no output stall or key derivation holds input
// reset: control clears; the last round key of the zero key is then derived with
// input stalled, and each key write stalls input until that derivation ends
module aes128_ecb_ctr_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aes_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aes_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned NR = aes_pkg::NUM_ROUNDS;

  logic [1:0]   mode_q;
  logic [127:0] key_q, iv_q, ctr_q, ctr_base, ctr_d;
  logic         kstart_q, key_busy, rk_busy;
  logic [127:0] rk_last;
  logic         cfg_we, in_acc;

  logic            v   [0:NR];
  aes_pkg::stage_t stg [0:NR];
  logic            en  [0:NR];
  logic            en_out;

  aes_pkg::stage_t stage_in;
  logic            out_v_q;
  aes_pkg::out_word_t out_q, out_d;
  logic [127:0]    res, xr;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      key_q    <= '0;
      iv_q     <= '0;
      kstart_q <= 1'b0;
    end else begin
      kstart_q <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index_i)
          aes_pkg::CFG_MODE:   mode_q <= cfg_data_i[1:0];
          aes_pkg::CFG_KEY_HI: begin
            key_q[127:64] <= cfg_data_i;
            kstart_q      <= 1'b1;
          end
          aes_pkg::CFG_KEY_LO: begin
            key_q[63:0] <= cfg_data_i;
            kstart_q    <= 1'b1;
          end
          aes_pkg::CFG_IV_HI:  iv_q[127:64] <= cfg_data_i;
          aes_pkg::CFG_IV_LO:  iv_q[63:0]   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  aes_key_last u_key_last (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kstart_q),
    .key_i   (key_q),
    .busy_o  (rk_busy),
    .rk_o    (rk_last)
  );

  assign key_busy = rk_busy || kstart_q;

  // stall chain: a stage moves when empty or when the next one moves
  assign en_out = !out_v_q || !out_stall_i;
  always_comb begin
    en[NR] = !v[NR] || en_out;
    for (int k = NR - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0] || key_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctr_base = in_word_i.restart ? {in_word_i.restart ? iv_q : ctr_q} : ctr_q;
  assign ctr_d    = mode_q[1] ? ctr_base + 128'd1 : ctr_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (in_acc) begin
      ctr_q <= ctr_d;
    end
  end

  always_comb begin
    stage_in.dec   = !mode_q[1] && mode_q[0];
    stage_in.ctr   = mode_q[1];
    stage_in.key   = stage_in.dec ? rk_last : key_q;
    stage_in.data  = {in_word_i.data_hi, in_word_i.data_lo};
    stage_in.count = in_word_i.valid_bytes;
    stage_in.st    = (mode_q[1] ? ctr_base : stage_in.data) ^ stage_in.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      stg[0] <= stage_in;
    end
  end

  for (genvar i = 1; i <= NR; i++) begin : g_cell
    aes_round_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en[i]),
      .valid_i    (v[i-1]),
      .stage_i    (stg[i-1]),
      .enc_rcon_i (aes_pkg::RCON[i]),
      .dec_rcon_i (aes_pkg::RCON[NR+1-i]),
      .last_i     (i == NR),
      .valid_o    (v[i]),
      .stage_o    (stg[i])
    );
  end

  // counter mode: xor data, zero the bytes past the count
  always_comb begin
    xr = stg[NR].st ^ stg[NR].data;
    for (int b = 0; b < 16; b++) begin
      res[127-8*b -: 8] = (5'(b) < stg[NR].count) ? xr[127-8*b -: 8] : 8'h00;
    end
    if (!stg[NR].ctr) begin
      res = stg[NR].st;
    end
    out_d.out_hi    = res[127:64];
    out_d.out_lo    = res[63:0];
    out_d.out_bytes = stg[NR].count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= v[NR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  a_no_accept_in_keygen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_busy |-> !in_acc)
    else $error("word accepted during key derivation");

  a_ctr_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_q[1] && !in_word_i.restart) |=> ctr_q == $past(ctr_q) + 128'd1)
    else $error("counter did not step");

  a_ecb_ctr_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !mode_q[1] && !in_word_i.restart) |=> $stable(ctr_q))
    else $error("counter moved in block mode");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule
